// ----- rtl/line_pixel_generator_assert.svh -----
// Assertion macros used by the line pixel generator datapath.
// Each macro expects clk and rst_n in scope.
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define LPG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpg: same-cycle check failed");

// Next-cycle implication.
`define LPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpg: next-cycle check failed");

`endif

// ----- rtl/lpg_pkg.sv -----
package lpg_pkg;

    localparam int COORD_BITS = 6;
    localparam int COLOR_BITS = 24;
    // doubled error plus one increment needs two more bits and a sign
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef enum logic
    {
        ST_IDLE,
        ST_WALK
    } lpg_state_t;

    typedef struct packed
    {
        logic load;  // latch a new command and set up the walk
        logic walk;  // emit the current pixel and advance
    } lpg_cmd_t;

    typedef struct packed
    {
        logic at_end;  // current pixel is the last of the line
    } lpg_status_t;

endpackage

// ----- rtl/lpg_ctrl.sv -----
module lpg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lpg_pkg::lpg_status_t status,
    output lpg_pkg::lpg_cmd_t    cmd,
    output logic                busy
);
    import lpg_pkg::*;

    lpg_state_t state_reg;
    lpg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.walk = 1'b0;
        busy     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                busy     = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/lpg_datapath.sv -----
module lpg_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpg_pkg::lpg_cmd_t              cmd,
    output lpg_pkg::lpg_status_t           status,
    input  logic [lpg_pkg::COORD_BITS-1:0] start_x,
    input  logic [lpg_pkg::COORD_BITS-1:0] start_y,
    input  logic [lpg_pkg::COORD_BITS-1:0] end_x,
    input  logic [lpg_pkg::COORD_BITS-1:0] end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0] color,
    output logic                           pixel_valid,
    output logic [lpg_pkg::COORD_BITS-1:0] pixel_x,
    output logic [lpg_pkg::COORD_BITS-1:0] pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);
    import lpg_pkg::*;
`include "line_pixel_generator_assert.svh"

    // setup: transpose steep lines, order endpoints by major coordinate
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  steep;
    logic [COORD_BITS-1:0] a_maj;
    logic [COORD_BITS-1:0] a_min;
    logic [COORD_BITS-1:0] b_maj;
    logic [COORD_BITS-1:0] b_min;
    logic                  swap;
    logic [COORD_BITS-1:0] s_maj;
    logic [COORD_BITS-1:0] s_min;
    logic [COORD_BITS-1:0] e_maj;
    logic [COORD_BITS-1:0] e_min;
    logic                  up;
    logic [COORD_BITS-1:0] admin;

    // walk state
    logic [COORD_BITS-1:0]      major_reg;
    logic [COORD_BITS-1:0]      end_reg;
    logic [COORD_BITS-1:0]      minor_reg;
    logic [COORD_BITS-1:0]      dmaj_reg;
    logic [COORD_BITS:0]        incr_reg;
    logic                       up_reg;
    logic                       steep_reg;
    logic signed [ERR_BITS-1:0] err_reg;
    logic [COLOR_BITS-1:0]      color_reg;

    logic signed [ERR_BITS-1:0] dmaj_s;
    logic signed [ERR_BITS-1:0] dmaj2_s;
    logic signed [ERR_BITS-1:0] err_sum;
    logic                       minor_step;
    logic signed [ERR_BITS-1:0] err_next;
    logic [COORD_BITS-1:0]      minor_next;

    // output word
    logic                  pixel_valid_reg;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [COLOR_BITS-1:0] pixel_color_reg;
    logic                  last_pixel_reg;

    always_comb
    begin
        adx   = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        ady   = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        steep = (adx < ady);
        a_maj = steep ? start_y : start_x;
        a_min = steep ? start_x : start_y;
        b_maj = steep ? end_y : end_x;
        b_min = steep ? end_x : end_y;
        swap  = (a_maj > b_maj);
        s_maj = swap ? b_maj : a_maj;
        s_min = swap ? b_min : a_min;
        e_maj = swap ? a_maj : b_maj;
        e_min = swap ? a_min : b_min;
        up    = (e_min > s_min);
        admin = up ? (e_min - s_min) : (s_min - e_min);
    end

    assign dmaj_s     = signed'(ERR_BITS'(dmaj_reg));
    assign dmaj2_s    = signed'(ERR_BITS'({dmaj_reg, 1'b0}));
    assign err_sum    = err_reg + signed'(ERR_BITS'(incr_reg));
    assign minor_step = (err_sum > dmaj_s);
    assign err_next   = minor_step ? (err_sum - dmaj2_s) : err_sum;
    assign minor_next = !minor_step ? minor_reg
                      : (up_reg ? (minor_reg + 1'b1) : (minor_reg - 1'b1));

    assign status.at_end = (major_reg == end_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            major_reg <= s_maj;
            end_reg   <= e_maj;
            minor_reg <= s_min;
            dmaj_reg  <= e_maj - s_maj;
            incr_reg  <= {admin, 1'b0};
            up_reg    <= up;
            steep_reg <= steep;
            err_reg   <= '0;
            color_reg <= color;
        end
        else if (cmd.walk)
        begin
            major_reg <= major_reg + 1'b1;
            minor_reg <= minor_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            pixel_valid_reg <= cmd.walk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            pixel_x_reg     <= steep_reg ? minor_reg : major_reg;
            pixel_y_reg     <= steep_reg ? major_reg : minor_reg;
            pixel_color_reg <= color_reg;
            last_pixel_reg  <= status.at_end;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

    // the final walk cycle must put out a flagged word
    `LPG_ASSERT_NEXT(a_last_flagged, cmd.walk && status.at_end, pixel_valid_reg && last_pixel_reg)
    // the walk never passes the far endpoint
    `LPG_ASSERT_IMPL(a_major_bound, cmd.walk, major_reg <= end_reg)
    // error term stays within (-dmaj, dmaj]
    `LPG_ASSERT_IMPL(a_err_bound, cmd.walk, (err_reg <= dmaj_s) && (err_reg > -dmaj_s || dmaj_reg == '0))

endmodule

// ----- rtl/line_pixel_generator.sv -----
// The load sets up the walk; the first walk state then registers the first pixel word.
// Throughput: one pixel word per cycle while busy; a command keeps busy high while the
// pixel walk of the datapath, the loop, runs from the near endpoint to the far one.
// A new command can be taken once busy falls, so a line is not accepted before the last is done.
// Reset (asynchronous, active low) returns the controller to idle and clears the strobe.
// The receiver cannot stall: each word shows for one cycle, marked by pixel_valid.
module line_pixel_generator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lpg_pkg::COORD_BITS-1:0] start_x,
    input  logic [lpg_pkg::COORD_BITS-1:0] start_y,
    input  logic [lpg_pkg::COORD_BITS-1:0] end_x,
    input  logic [lpg_pkg::COORD_BITS-1:0] end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0] color,
    output logic                           pixel_valid,
    output logic [lpg_pkg::COORD_BITS-1:0] pixel_x,
    output logic [lpg_pkg::COORD_BITS-1:0] pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);
    import lpg_pkg::*;

    // Controller: idle until start, then hold in the walk until the last pixel.
    lpg_cmd_t    cmd;
    lpg_status_t status;

    lpg_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: on load, transpose and order the endpoints and latch the
    // doubled increment; on each walk cycle, drop one pixel word into the
    // output register and advance the major coordinate, stepping the minor
    // one when the doubled error passes the major length.
    lpg_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color       (color),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule
